@@ hdl/rsq_pkg.sv @@
package rsq_pkg;

    // Widths of the configuration write channel.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Widths of the scan counters.
    localparam int MOVE_W = 8;
    localparam int STEP_W = 12;
    localparam int WAIT_W = 16;
    localparam int COIL_W = 4;

    // Length of the pause between two scans, in ticks.
    localparam logic [WAIT_W-1:0] PAUSE_TICKS = 16'd2000;

    // Actions that can run back to back in one tick before a wait starts.
    // The longest such chain is five actions: the end of a y pass through the
    // return-home checks into the pause, or the end of the pause through the
    // scan start into the next frame pulse.
    localparam int CHAIN_DEPTH = 5;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_Y_MOVES      = 3'd0,
        CFG_X_MOVES      = 3'd1,
        CFG_ARM_MOVES    = 3'd2,
        CFG_Y_STEPS      = 3'd3,
        CFG_X_STEPS      = 3'd4,
        CFG_ARM_STEPS    = 3'd5,
        CFG_SETTLE_TICKS = 3'd6,
        CFG_STEP_TICKS   = 3'd7
    } cfg_idx_t;

    // Configuration register set.
    typedef struct packed {
        logic [MOVE_W-1:0] y_moves;
        logic [MOVE_W-1:0] x_moves;
        logic [MOVE_W-1:0] arm_moves;
        logic [STEP_W-1:0] y_steps_per_move;
        logic [STEP_W-1:0] x_steps_per_move;
        logic [STEP_W-1:0] arm_steps_per_move;
        logic [WAIT_W-1:0] settle_ticks;
        logic [7:0]        step_ticks;
    } cfg_t;

endpackage

@@ hdl/three_axis_raster_scan_stepper_sequencer.sv @@
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_stall    tick
// result    out        out_valid / out_stall  y_coils, x_coils, arm_coils,
//                                             frame_pulse, scanning
// config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One request is taken every cycle while in_stall is low; its result is valid in the next cycle.
// A tick runs every sequencer action up to the next wait in that same cycle.
// The sequencer state registers double as the result register.
// Reset (rst_n low, asynchronous) loads the default registers and the scan start.
// While a result is held by out_stall, in_stall is high and no request is taken.
module three_axis_raster_scan_stepper_sequencer
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             tick,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [rsq_pkg::COIL_W-1:0]       y_coils,
    output logic [rsq_pkg::COIL_W-1:0]       x_coils,
    output logic [rsq_pkg::COIL_W-1:0]       arm_coils,
    output logic                             frame_pulse,
    output logic                             scanning,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rsq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rsq_pkg::CFG_DATA_W-1:0]   cfg_data
);

    typedef enum logic [4:0] {
        M_START = 5'd0,
        M_ARM   = 5'd1,
        M_XPASS = 5'd2,
        M_YLOOP = 5'd3,
        M_YOFF  = 5'd4,
        M_YPRE  = 5'd5,
        M_YSTEP = 5'd6,
        M_YNEXT = 5'd7,
        M_YFOFF = 5'd8,
        M_YFLIP = 5'd9,
        M_YDONE = 5'd10,
        M_XSTEP = 5'd11,
        M_XNEXT = 5'd12,
        M_RX    = 5'd13,
        M_RY    = 5'd14,
        M_XDONE = 5'd15,
        M_ASTEP = 5'd16,
        M_ANEXT = 5'd17,
        M_RA    = 5'd18,
        M_PAUSE = 5'd19
    } mode_t;

    typedef struct packed {
        mode_t                              mode;
        logic [rsq_pkg::MOVE_W-1:0]         arm_index;
        logic [rsq_pkg::MOVE_W-1:0]         x_index;
        logic [rsq_pkg::MOVE_W-1:0]         y_index;
        logic [rsq_pkg::STEP_W-1:0]         step_index;
        logic [rsq_pkg::WAIT_W-1:0]         wait_count;
        logic                               y_dir;
        logic [1:0]                         y_phase;
        logic [1:0]                         x_phase;
        logic [1:0]                         arm_phase;
        logic [3*rsq_pkg::COIL_W-1:0]       coil_latch;
        logic                               led_level;
    } seq_state_t;

    seq_state_t     st_reg;
    seq_state_t     st_next;
    rsq_pkg::cfg_t  cfg_reg;
    rsq_pkg::cfg_t  cfg_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic           in_accept;

    // A wait of zero ticks still lasts one tick.
    function automatic logic [rsq_pkg::WAIT_W-1:0] wait_len(
        input logic [rsq_pkg::WAIT_W-1:0] n);
        return (n == '0) ? rsq_pkg::WAIT_W'(1) : n;
    endfunction

    // Wave drive: forward steps (dir low) walk the coils down, return steps (dir high) walk them up.
    function automatic logic [rsq_pkg::COIL_W-1:0] coil_for(
        input logic [1:0] phase,
        input logic       dir);
        return dir ? (4'b0001 << phase) : (4'b1000 >> phase);
    endfunction

    // One action of the scan sequencer.
    function automatic seq_state_t act_step(
        input seq_state_t    s,
        input rsq_pkg::cfg_t c);
        seq_state_t                  n;
        logic [rsq_pkg::STEP_W-1:0]  step_inc;
        logic [rsq_pkg::WAIT_W-1:0]  settle_wait;
        logic [rsq_pkg::WAIT_W-1:0]  step_wait;
        n           = s;
        step_inc    = s.step_index + rsq_pkg::STEP_W'(1);
        settle_wait = wait_len(c.settle_ticks);
        step_wait   = wait_len(rsq_pkg::WAIT_W'(c.step_ticks));
        unique case (s.mode)
            M_ARM:
            begin
                n.x_index = '0;
                n.mode    = M_XPASS;
            end
            M_XPASS:
            begin
                n.y_index = '0;
                n.mode    = M_YLOOP;
            end
            M_YLOOP:
            begin
                n.led_level  = 1'b1;
                n.wait_count = settle_wait;
                n.mode       = (s.y_index < c.y_moves) ? M_YOFF : M_YFOFF;
            end
            M_YOFF:
            begin
                n.led_level  = 1'b0;
                n.wait_count = settle_wait;
                n.mode       = M_YPRE;
            end
            M_YPRE:
            begin
                n.wait_count = settle_wait;
                n.step_index = '0;
                n.mode       = M_YSTEP;
            end
            M_YSTEP:
            begin
                if (s.step_index < c.y_steps_per_move)
                begin
                    n.coil_latch[3:0] = coil_for(s.y_phase, s.y_dir);
                    n.y_phase         = s.y_phase + 2'd1;
                    n.step_index      = step_inc;
                    n.wait_count      = step_wait;
                end
                else
                begin
                    n.wait_count = settle_wait;
                    n.mode       = M_YNEXT;
                end
            end
            M_YNEXT:
            begin
                n.y_index = s.y_index + rsq_pkg::MOVE_W'(1);
                n.mode    = M_YLOOP;
            end
            M_YFOFF:
            begin
                n.led_level  = 1'b0;
                n.wait_count = settle_wait;
                n.mode       = M_YFLIP;
            end
            M_YFLIP:
            begin
                n.y_dir      = ~s.y_dir;
                n.wait_count = settle_wait;
                n.mode       = M_YDONE;
            end
            M_YDONE:
            begin
                n.step_index = '0;
                if (s.x_index < c.x_moves)
                begin
                    n.mode = M_XSTEP;
                end
                else
                begin
                    n.x_index = '0;
                    n.mode    = M_RX;
                end
            end
            M_XSTEP:
            begin
                if (s.step_index < c.x_steps_per_move)
                begin
                    n.coil_latch[7:4] = coil_for(s.x_phase, 1'b0);
                    n.x_phase         = s.x_phase + 2'd1;
                    n.step_index      = step_inc;
                    n.wait_count      = step_wait;
                end
                else
                begin
                    n.wait_count = settle_wait;
                    n.mode       = M_XNEXT;
                end
            end
            M_XNEXT:
            begin
                n.x_index = s.x_index + rsq_pkg::MOVE_W'(1);
                n.mode    = M_XPASS;
            end
            M_RX:
            begin
                // Step x back home, one motor step per wait.
                if (s.x_index < c.x_moves && s.step_index < c.x_steps_per_move)
                begin
                    n.coil_latch[7:4] = coil_for(s.x_phase, 1'b1);
                    n.x_phase         = s.x_phase + 2'd1;
                    if (step_inc >= c.x_steps_per_move)
                    begin
                        n.step_index = '0;
                        n.x_index    = s.x_index + rsq_pkg::MOVE_W'(1);
                    end
                    else
                    begin
                        n.step_index = step_inc;
                    end
                    n.wait_count = step_wait;
                end
                else
                begin
                    n.step_index = '0;
                    if (s.y_dir)
                    begin
                        n.y_index = '0;
                        n.mode    = M_RY;
                    end
                    else
                    begin
                        n.mode = M_XDONE;
                    end
                end
            end
            M_RY:
            begin
                // Bring y back when the last y pass left it away from home.
                if (s.y_index < c.y_moves && s.step_index < c.y_steps_per_move)
                begin
                    n.coil_latch[3:0] = coil_for(s.y_phase, s.y_dir);
                    n.y_phase         = s.y_phase + 2'd1;
                    if (step_inc >= c.y_steps_per_move)
                    begin
                        n.step_index = '0;
                        n.y_index    = s.y_index + rsq_pkg::MOVE_W'(1);
                    end
                    else
                    begin
                        n.step_index = step_inc;
                    end
                    n.wait_count = step_wait;
                end
                else
                begin
                    n.step_index = '0;
                    n.mode       = M_XDONE;
                end
            end
            M_XDONE:
            begin
                n.step_index = '0;
                if (s.arm_index < c.arm_moves)
                begin
                    n.mode = M_ASTEP;
                end
                else
                begin
                    n.arm_index = '0;
                    n.mode      = M_RA;
                end
            end
            M_ASTEP:
            begin
                if (s.step_index < c.arm_steps_per_move)
                begin
                    n.coil_latch[11:8] = coil_for(s.arm_phase, 1'b0);
                    n.arm_phase        = s.arm_phase + 2'd1;
                    n.step_index       = step_inc;
                    n.wait_count       = step_wait;
                end
                else
                begin
                    n.wait_count = settle_wait;
                    n.mode       = M_ANEXT;
                end
            end
            M_ANEXT:
            begin
                n.y_dir     = 1'b0;
                n.arm_index = s.arm_index + rsq_pkg::MOVE_W'(1);
                n.mode      = M_ARM;
            end
            M_RA:
            begin
                // Step the arm home, then start the pause.
                if (s.arm_index < c.arm_moves && s.step_index < c.arm_steps_per_move)
                begin
                    n.coil_latch[11:8] = coil_for(s.arm_phase, 1'b1);
                    n.arm_phase        = s.arm_phase + 2'd1;
                    if (step_inc >= c.arm_steps_per_move)
                    begin
                        n.step_index = '0;
                        n.arm_index  = s.arm_index + rsq_pkg::MOVE_W'(1);
                    end
                    else
                    begin
                        n.step_index = step_inc;
                    end
                    n.wait_count = step_wait;
                end
                else
                begin
                    n.step_index = '0;
                    n.mode       = M_PAUSE;
                    n.wait_count = wait_len(rsq_pkg::PAUSE_TICKS);
                end
            end
            M_PAUSE:
            begin
                n.mode = M_START;
            end
            default:
            begin
                // Scan start; any code outside the list acts the same way.
                n.y_dir     = 1'b0;
                n.arm_index = '0;
                n.mode      = M_ARM;
            end
        endcase
        return n;
    endfunction

    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;
    assign cfg_ready = 1'b1;

    // Next state for one tick: count the wait down, then run the actions
    // that follow until a new wait starts.
    always_comb
    begin
        st_next = st_reg;
        if (in_accept && tick)
        begin
            if (st_next.wait_count != '0)
            begin
                st_next.wait_count = st_next.wait_count - rsq_pkg::WAIT_W'(1);
            end
            for (int i = 0; i < rsq_pkg::CHAIN_DEPTH; i++)
            begin
                if (st_next.wait_count == '0)
                begin
                    st_next = act_step(st_next, cfg_reg);
                end
            end
        end
    end

    // Result valid: set by a request, cleared once taken.
    always_comb
    begin
        if (in_accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    // Configuration register writes.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (rsq_pkg::cfg_idx_t'(cfg_index))
                rsq_pkg::CFG_Y_MOVES:      cfg_next.y_moves            = cfg_data[7:0];
                rsq_pkg::CFG_X_MOVES:      cfg_next.x_moves            = cfg_data[7:0];
                rsq_pkg::CFG_ARM_MOVES:    cfg_next.arm_moves          = cfg_data[7:0];
                rsq_pkg::CFG_Y_STEPS:      cfg_next.y_steps_per_move   = cfg_data[11:0];
                rsq_pkg::CFG_X_STEPS:      cfg_next.x_steps_per_move   = cfg_data[11:0];
                rsq_pkg::CFG_ARM_STEPS:    cfg_next.arm_steps_per_move = cfg_data[11:0];
                rsq_pkg::CFG_SETTLE_TICKS: cfg_next.settle_ticks       = cfg_data;
                rsq_pkg::CFG_STEP_TICKS:   cfg_next.step_ticks         = cfg_data[7:0];
                default:                   cfg_next                    = cfg_reg;
            endcase
        end
    end

    // State, configuration and result valid registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.mode                <= M_START;
            st_reg.arm_index           <= '0;
            st_reg.x_index             <= '0;
            st_reg.y_index             <= '0;
            st_reg.step_index          <= '0;
            st_reg.wait_count          <= '0;
            st_reg.y_dir               <= 1'b0;
            st_reg.y_phase             <= '0;
            st_reg.x_phase             <= '0;
            st_reg.arm_phase           <= '0;
            st_reg.coil_latch          <= '0;
            st_reg.led_level           <= 1'b0;
            cfg_reg.y_moves            <= 8'd2;
            cfg_reg.x_moves            <= 8'd2;
            cfg_reg.arm_moves          <= 8'd2;
            cfg_reg.y_steps_per_move   <= 12'd200;
            cfg_reg.x_steps_per_move   <= 12'd200;
            cfg_reg.arm_steps_per_move <= 12'd200;
            cfg_reg.settle_ticks       <= 16'd200;
            cfg_reg.step_ticks         <= 8'd3;
            out_valid_reg              <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The result is the state left by the last request.
    assign out_valid   = out_valid_reg;
    assign y_coils     = st_reg.coil_latch[3:0];
    assign x_coils     = st_reg.coil_latch[7:4];
    assign arm_coils   = st_reg.coil_latch[11:8];
    assign frame_pulse = st_reg.led_level;
    assign scanning    = (st_reg.mode != M_PAUSE);

endmodule

@@ hdl/rsq_checker.sv @@
module rsq_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic                             tick,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [rsq_pkg::COIL_W-1:0]       y_coils,
    input  logic [rsq_pkg::COIL_W-1:0]       x_coils,
    input  logic [rsq_pkg::COIL_W-1:0]       arm_coils,
    input  logic                             frame_pulse,
    input  logic                             scanning,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [rsq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rsq_pkg::CFG_DATA_W-1:0]   cfg_data
);

    // Every taken request yields a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> out_valid)
        else $error("request taken but no result followed");

    // No result appears without a request behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!(in_valid && !in_stall) && !(out_valid && out_stall)) |=> !out_valid)
        else $error("result appeared without a request");

    // A held result keeps all of its fields.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> ($stable(y_coils) && $stable(x_coils)
            && $stable(arm_coils) && $stable(frame_pulse) && $stable(scanning)))
        else $error("held result changed");

    // Wave drive never energizes two coils of one motor.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($onehot0(y_coils) && $onehot0(x_coils) && $onehot0(arm_coils)))
        else $error("more than one coil driven on a motor");

    // The frame pulse is low throughout the pause between scans.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !scanning) |-> !frame_pulse)
        else $error("frame pulse high during pause");

endmodule

bind three_axis_raster_scan_stepper_sequencer rsq_checker u_rsq_checker (.*);

@@ tb/three_axis_raster_scan_stepper_sequencer_tb.sv @@
`timescale 1ns / 1ps

module three_axis_raster_scan_stepper_sequencer_tb;

    // Axis slots of the coil, phase and move-count arrays.
    localparam int AX_Y   = 0;
    localparam int AX_X   = 1;
    localparam int AX_ARM = 2;

    localparam int NUM_PHASES = 10;

    // Own encoding of the sequencer position.
    typedef enum logic [4:0] {
        SEQ_START,
        SEQ_ARM_BEGIN,
        SEQ_X_PASS,
        SEQ_Y_FRAME_ON,
        SEQ_Y_FRAME_OFF,
        SEQ_Y_PRESETTLE,
        SEQ_Y_STEP,
        SEQ_Y_NEXT,
        SEQ_Y_LAST_OFF,
        SEQ_Y_FLIP,
        SEQ_Y_DONE,
        SEQ_X_STEP,
        SEQ_X_NEXT,
        SEQ_HOME_X,
        SEQ_HOME_Y,
        SEQ_X_DONE,
        SEQ_ARM_STEP,
        SEQ_ARM_NEXT,
        SEQ_HOME_ARM,
        SEQ_PAUSE
    } seq_mode_t;

    typedef struct packed {
        logic [rsq_pkg::COIL_W-1:0] y_coils;
        logic [rsq_pkg::COIL_W-1:0] x_coils;
        logic [rsq_pkg::COIL_W-1:0] arm_coils;
        logic                       frame_pulse;
        logic                       scanning;
    } scan_out_t;

    typedef enum logic {
        ROW_TICK,
        ROW_WRITE
    } row_kind_t;

    typedef struct packed {
        row_kind_t                      kind;
        logic                           tick;
        rsq_pkg::cfg_idx_t              index;
        logic [rsq_pkg::CFG_DATA_W-1:0] data;
        logic                           typed;
        scan_out_t                      res;
    } row_t;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_stall;
    logic                             tick;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic [rsq_pkg::COIL_W-1:0]       y_coils;
    logic [rsq_pkg::COIL_W-1:0]       x_coils;
    logic [rsq_pkg::COIL_W-1:0]       arm_coils;
    logic                             frame_pulse;
    logic                             scanning;
    logic                             cfg_valid;
    logic                             cfg_ready;
    logic [rsq_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [rsq_pkg::CFG_DATA_W-1:0]   cfg_data;

    int  err_count = 0;
    int  hold_cnt = 0;
    bit  calm = 1'b0;

    // Expected coil and LED states, oldest first.
    scan_out_t drive_q[$];
    row_t      dir_rows[$];

    // Shadow copy of the configuration registers.
    logic [rsq_pkg::MOVE_W-1:0] n_moves [3];
    logic [rsq_pkg::STEP_W-1:0] n_steps [3];
    logic [rsq_pkg::WAIT_W-1:0] settle;
    logic [7:0]                 step_wait;

    // Shadow copy of the sequencer state.
    seq_mode_t                  seq_mode;
    logic [rsq_pkg::MOVE_W-1:0] move_idx [3];
    logic [rsq_pkg::STEP_W-1:0] step_idx;
    logic [rsq_pkg::WAIT_W-1:0] wait_cnt;
    logic                       y_dir;
    logic [1:0]                 coil_phase [3];
    logic [rsq_pkg::COIL_W-1:0] coil [3];
    logic                       led;

    three_axis_raster_scan_stepper_sequencer u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .tick        (tick),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .y_coils     (y_coils),
        .x_coils     (x_coils),
        .arm_coils   (arm_coils),
        .frame_pulse (frame_pulse),
        .scanning    (scanning),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    // Idle length for either side: mostly none, sometimes short, rarely long.
    function automatic int gap_len();
        int unsigned p;
        if (calm)
        begin
            return 0;
        end
        p = $urandom_range(0, 99);
        if (p < 60)
        begin
            return 0;
        end
        if (p < 95)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Register value for a random phase: mostly small, sometimes zero or the extreme.
    function automatic logic [15:0] pick_value(int unsigned top, logic [15:0] extreme);
        logic [31:0] r;
        r = $urandom_range(0, 11);
        if (r == 0)
        begin
            return 16'd0;
        end
        if (r == 1)
        begin
            return extreme;
        end
        r = $urandom_range(1, top);
        return r[15:0];
    endfunction

    function automatic void load_wait(input logic [rsq_pkg::WAIT_W-1:0] n);
        wait_cnt = (n != '0) ? n : 16'd1;
    endfunction

    // One wave-drive step: a single coil on, then the phase moves on.
    function automatic void drive_coil(input int ax, input logic dir);
        logic [1:0] p;
        p = coil_phase[ax];
        coil[ax] = dir ? (4'b0001 << p) : (4'b1000 >> p);
        coil_phase[ax] = p + 2'd1;
    endfunction

    // One step back toward home; returns 0 when the axis is already home.
    function automatic bit home_step(input int ax, input logic dir);
        if (move_idx[ax] < n_moves[ax] && step_idx < n_steps[ax])
        begin
            drive_coil(ax, dir);
            step_idx = step_idx + 1'b1;
            if (step_idx >= n_steps[ax])
            begin
                step_idx = '0;
                move_idx[ax] = move_idx[ax] + 1'b1;
            end
            load_wait({8'd0, step_wait});
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void reset_scan();
        n_moves[AX_Y]   = 8'd2;
        n_moves[AX_X]   = 8'd2;
        n_moves[AX_ARM] = 8'd2;
        n_steps[AX_Y]   = 12'd200;
        n_steps[AX_X]   = 12'd200;
        n_steps[AX_ARM] = 12'd200;
        settle          = 16'd200;
        step_wait       = 8'd3;
        seq_mode        = SEQ_START;
        step_idx        = '0;
        wait_cnt        = '0;
        y_dir           = 1'b0;
        led             = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            move_idx[a]   = '0;
            coil_phase[a] = '0;
            coil[a]       = '0;
        end
    endfunction

    function automatic void apply_cfg(input rsq_pkg::cfg_idx_t idx,
                                      input logic [rsq_pkg::CFG_DATA_W-1:0] v);
        case (idx)
            rsq_pkg::CFG_Y_MOVES:      n_moves[AX_Y]   = v[7:0];
            rsq_pkg::CFG_X_MOVES:      n_moves[AX_X]   = v[7:0];
            rsq_pkg::CFG_ARM_MOVES:    n_moves[AX_ARM] = v[7:0];
            rsq_pkg::CFG_Y_STEPS:      n_steps[AX_Y]   = v[11:0];
            rsq_pkg::CFG_X_STEPS:      n_steps[AX_X]   = v[11:0];
            rsq_pkg::CFG_ARM_STEPS:    n_steps[AX_ARM] = v[11:0];
            rsq_pkg::CFG_SETTLE_TICKS: settle          = v;
            rsq_pkg::CFG_STEP_TICKS:   step_wait       = v[7:0];
            default: ;
        endcase
    endfunction

    // One action of the scan sequence; runs whenever no wait is pending.
    function automatic void run_action();
        case (seq_mode)
            SEQ_ARM_BEGIN:
            begin
                move_idx[AX_X] = '0;
                seq_mode = SEQ_X_PASS;
            end
            SEQ_X_PASS:
            begin
                move_idx[AX_Y] = '0;
                seq_mode = SEQ_Y_FRAME_ON;
            end
            SEQ_Y_FRAME_ON:
            begin
                led = 1'b1;
                load_wait(settle);
                if (move_idx[AX_Y] < n_moves[AX_Y])
                    seq_mode = SEQ_Y_FRAME_OFF;
                else
                    seq_mode = SEQ_Y_LAST_OFF;
            end
            SEQ_Y_FRAME_OFF:
            begin
                led = 1'b0;
                load_wait(settle);
                seq_mode = SEQ_Y_PRESETTLE;
            end
            SEQ_Y_PRESETTLE:
            begin
                load_wait(settle);
                step_idx = '0;
                seq_mode = SEQ_Y_STEP;
            end
            SEQ_Y_STEP:
            begin
                if (step_idx < n_steps[AX_Y])
                begin
                    drive_coil(AX_Y, y_dir);
                    step_idx = step_idx + 1'b1;
                    load_wait({8'd0, step_wait});
                end
                else
                begin
                    load_wait(settle);
                    seq_mode = SEQ_Y_NEXT;
                end
            end
            SEQ_Y_NEXT:
            begin
                move_idx[AX_Y] = move_idx[AX_Y] + 1'b1;
                seq_mode = SEQ_Y_FRAME_ON;
            end
            SEQ_Y_LAST_OFF:
            begin
                led = 1'b0;
                load_wait(settle);
                seq_mode = SEQ_Y_FLIP;
            end
            SEQ_Y_FLIP:
            begin
                y_dir = ~y_dir;
                load_wait(settle);
                seq_mode = SEQ_Y_DONE;
            end
            SEQ_Y_DONE:
            begin
                step_idx = '0;
                if (move_idx[AX_X] < n_moves[AX_X])
                begin
                    seq_mode = SEQ_X_STEP;
                end
                else
                begin
                    move_idx[AX_X] = '0;
                    seq_mode = SEQ_HOME_X;
                end
            end
            SEQ_X_STEP:
            begin
                if (step_idx < n_steps[AX_X])
                begin
                    drive_coil(AX_X, 1'b0);
                    step_idx = step_idx + 1'b1;
                    load_wait({8'd0, step_wait});
                end
                else
                begin
                    load_wait(settle);
                    seq_mode = SEQ_X_NEXT;
                end
            end
            SEQ_X_NEXT:
            begin
                move_idx[AX_X] = move_idx[AX_X] + 1'b1;
                seq_mode = SEQ_X_PASS;
            end
            SEQ_HOME_X:
            begin
                if (!home_step(AX_X, 1'b1))
                begin
                    step_idx = '0;
                    if (y_dir)
                    begin
                        move_idx[AX_Y] = '0;
                        seq_mode = SEQ_HOME_Y;
                    end
                    else
                    begin
                        seq_mode = SEQ_X_DONE;
                    end
                end
            end
            SEQ_HOME_Y:
            begin
                if (!home_step(AX_Y, y_dir))
                begin
                    step_idx = '0;
                    seq_mode = SEQ_X_DONE;
                end
            end
            SEQ_X_DONE:
            begin
                step_idx = '0;
                if (move_idx[AX_ARM] < n_moves[AX_ARM])
                begin
                    seq_mode = SEQ_ARM_STEP;
                end
                else
                begin
                    move_idx[AX_ARM] = '0;
                    seq_mode = SEQ_HOME_ARM;
                end
            end
            SEQ_ARM_STEP:
            begin
                if (step_idx < n_steps[AX_ARM])
                begin
                    drive_coil(AX_ARM, 1'b0);
                    step_idx = step_idx + 1'b1;
                    load_wait({8'd0, step_wait});
                end
                else
                begin
                    load_wait(settle);
                    seq_mode = SEQ_ARM_NEXT;
                end
            end
            SEQ_ARM_NEXT:
            begin
                y_dir = 1'b0;
                move_idx[AX_ARM] = move_idx[AX_ARM] + 1'b1;
                seq_mode = SEQ_ARM_BEGIN;
            end
            SEQ_HOME_ARM:
            begin
                if (!home_step(AX_ARM, 1'b1))
                begin
                    step_idx = '0;
                    seq_mode = SEQ_PAUSE;
                    load_wait(rsq_pkg::PAUSE_TICKS);
                end
            end
            SEQ_PAUSE:
            begin
                seq_mode = SEQ_START;
            end
            default:
            begin
                y_dir = 1'b0;
                move_idx[AX_ARM] = '0;
                seq_mode = SEQ_ARM_BEGIN;
            end
        endcase
    endfunction

    // Advance the shadow scan by one request and return the outputs it leaves.
    function automatic scan_out_t predict_tick(input logic t);
        scan_out_t r;
        int        guard;
        if (t)
        begin
            if (wait_cnt != '0)
                wait_cnt = wait_cnt - 1'b1;
            for (guard = 0; guard < 64 && wait_cnt == '0; guard++)
                run_action();
        end
        r.y_coils     = coil[AX_Y];
        r.x_coils     = coil[AX_X];
        r.arm_coils   = coil[AX_ARM];
        r.frame_pulse = led;
        r.scanning    = (seq_mode != SEQ_PAUSE);
        return r;
    endfunction

    // Send one tick request after a random gap and record what it should produce.
    task automatic send_tick(input logic t, input logic typed, input scan_out_t typed_res);
        int        gap;
        scan_out_t res;
        gap = gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        tick     <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        res = predict_tick(t);
        if (typed)
            res = typed_res;
        drive_q.push_back(res);
    endtask

    // Register write; unused upper data bits sometimes carry junk.
    task automatic write_reg(input rsq_pkg::cfg_idx_t idx,
                             input logic [rsq_pkg::CFG_DATA_W-1:0] v);
        logic [rsq_pkg::CFG_DATA_W-1:0] data;
        logic [31:0]                    rnd;
        data = v;
        rnd  = $urandom;
        if (rnd[31:30] == 2'b00)
        begin
            case (idx)
                rsq_pkg::CFG_Y_MOVES, rsq_pkg::CFG_X_MOVES,
                rsq_pkg::CFG_ARM_MOVES, rsq_pkg::CFG_STEP_TICKS:
                    data[15:8] = rnd[7:0];
                rsq_pkg::CFG_Y_STEPS, rsq_pkg::CFG_X_STEPS, rsq_pkg::CFG_ARM_STEPS:
                    data[15:12] = rnd[3:0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_cfg(idx, data);
    endtask

    // Stop sending and wait until every expected result has been seen.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (drive_q.size() != 0)
            @(posedge clk);
    endtask

    // Result side back-pressure.
    always @(posedge clk)
    begin
        if (hold_cnt > 0)
        begin
            hold_cnt = hold_cnt - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            hold_cnt = gap_len();
            out_stall <= 1'b0;
        end
    end

    // Compare every accepted result with the oldest expectation.
    always @(posedge clk)
    begin : result_check
        scan_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (drive_q.size() == 0)
            begin
                $error("result arrived with no pending request");
                err_count = err_count + 1;
            end
            else
            begin
                want = drive_q.pop_front();
                if (y_coils !== want.y_coils)
                begin
                    $error("y_coils expected %0h actual %0h", want.y_coils, y_coils);
                    err_count = err_count + 1;
                end
                if (x_coils !== want.x_coils)
                begin
                    $error("x_coils expected %0h actual %0h", want.x_coils, x_coils);
                    err_count = err_count + 1;
                end
                if (arm_coils !== want.arm_coils)
                begin
                    $error("arm_coils expected %0h actual %0h", want.arm_coils, arm_coils);
                    err_count = err_count + 1;
                end
                if (frame_pulse !== want.frame_pulse)
                begin
                    $error("frame_pulse expected %0b actual %0b",
                           want.frame_pulse, frame_pulse);
                    err_count = err_count + 1;
                end
                if (scanning !== want.scanning)
                begin
                    $error("scanning expected %0b actual %0b", want.scanning, scanning);
                    err_count = err_count + 1;
                end
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        int                             ph;
        int                             n_items;
        row_t                           row;
        rsq_pkg::cfg_idx_t              ci;
        logic [rsq_pkg::CFG_DATA_W-1:0] vals [8];

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        tick      = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        reset_scan();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: kind, tick, register, data, typed result, result.
        // A held tick after reset shows the idle outputs.
        dir_rows.push_back('{ROW_TICK, 1'b0, rsq_pkg::CFG_Y_MOVES, 16'd0, 1'b1,
                             '{4'h0, 4'h0, 4'h0, 1'b0, 1'b1}});
        // Zero-length waits, an empty x pass and an empty arm pass.
        dir_rows.push_back('{ROW_WRITE, 1'b0, rsq_pkg::CFG_SETTLE_TICKS, 16'd0, 1'b0, '0});
        dir_rows.push_back('{ROW_WRITE, 1'b0, rsq_pkg::CFG_STEP_TICKS, 16'd0, 1'b0, '0});
        dir_rows.push_back('{ROW_WRITE, 1'b0, rsq_pkg::CFG_Y_MOVES, 16'd1, 1'b0, '0});
        dir_rows.push_back('{ROW_WRITE, 1'b0, rsq_pkg::CFG_Y_STEPS, 16'd2, 1'b0, '0});
        dir_rows.push_back('{ROW_WRITE, 1'b0, rsq_pkg::CFG_X_MOVES, 16'd0, 1'b0, '0});
        dir_rows.push_back('{ROW_WRITE, 1'b0, rsq_pkg::CFG_ARM_MOVES, 16'd0, 1'b0, '0});
        // The first tick lights the frame LED.
        dir_rows.push_back('{ROW_TICK, 1'b1, rsq_pkg::CFG_Y_MOVES, 16'd0, 1'b1,
                             '{4'h0, 4'h0, 4'h0, 1'b1, 1'b1}});
        dir_rows.push_back('{ROW_TICK, 1'b0, rsq_pkg::CFG_Y_MOVES, 16'd0, 1'b0, '0});
        repeat (3)
            dir_rows.push_back('{ROW_TICK, 1'b1, rsq_pkg::CFG_Y_MOVES, 16'd0, 1'b0, '0});
        // Shorten the y move while it is under way.
        dir_rows.push_back('{ROW_WRITE, 1'b0, rsq_pkg::CFG_Y_STEPS, 16'd1, 1'b0, '0});
        repeat (5)
            dir_rows.push_back('{ROW_TICK, 1'b1, rsq_pkg::CFG_Y_MOVES, 16'd0, 1'b0, '0});

        foreach (dir_rows[r])
        begin
            row = dir_rows[r];
            if (row.kind == ROW_WRITE)
            begin
                wait_drained();
                write_reg(row.index, row.data);
            end
            else
            begin
                cfg_valid <= 1'b0;
                send_tick(row.tick, row.typed, row.res);
            end
        end

        // Random phases, each after a fresh set of register writes.
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            wait_drained();
            calm = (ph % 4 == 3);
            if (ph == NUM_PHASES - 2)
            begin
                foreach (vals[i])
                    vals[i] = '0;
            end
            else if (ph == NUM_PHASES - 1)
            begin
                vals[rsq_pkg::CFG_Y_MOVES]      = 16'd255;
                vals[rsq_pkg::CFG_X_MOVES]      = 16'd255;
                vals[rsq_pkg::CFG_ARM_MOVES]    = 16'd255;
                vals[rsq_pkg::CFG_Y_STEPS]      = 16'd4095;
                vals[rsq_pkg::CFG_X_STEPS]      = 16'd4095;
                vals[rsq_pkg::CFG_ARM_STEPS]    = 16'd4095;
                vals[rsq_pkg::CFG_SETTLE_TICKS] = 16'd65535;
                vals[rsq_pkg::CFG_STEP_TICKS]   = 16'd255;
            end
            else
            begin
                vals[rsq_pkg::CFG_Y_MOVES]      = pick_value(3, 16'd255);
                vals[rsq_pkg::CFG_X_MOVES]      = pick_value(3, 16'd255);
                vals[rsq_pkg::CFG_ARM_MOVES]    = pick_value(3, 16'd255);
                vals[rsq_pkg::CFG_Y_STEPS]      = pick_value(4, 16'd4095);
                vals[rsq_pkg::CFG_X_STEPS]      = pick_value(4, 16'd4095);
                vals[rsq_pkg::CFG_ARM_STEPS]    = pick_value(4, 16'd4095);
                vals[rsq_pkg::CFG_SETTLE_TICKS] = pick_value(3, 16'd0);
                vals[rsq_pkg::CFG_STEP_TICKS]   = pick_value(2, 16'd0);
            end
            ci = ci.first();
            repeat (8)
            begin
                write_reg(ci, vals[ci]);
                ci = ci.next();
            end
            cfg_valid <= 1'b0;

            n_items = 49;
            repeat (n_items)
                send_tick($urandom_range(0, 9) != 0, 1'b0, '0);
        end

        wait_drained();
        repeat (4) @(posedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ three_axis_raster_scan_stepper_sequencer.f @@
hdl/rsq_pkg.sv
hdl/three_axis_raster_scan_stepper_sequencer.sv
hdl/rsq_checker.sv
tb/three_axis_raster_scan_stepper_sequencer_tb.sv
